// ===== rtl/ntsu_pkg.sv =====
package ntsu_pkg;

    // Shared serial divider sizes
    localparam int unsigned DIV_W   = 33;   // dividend / quotient shift register
    localparam int unsigned DVSR_W  = 23;   // divisor and remainder
    localparam int unsigned STEP_W  = 6;    // step counter, holds DIV_W

    // Constant divisors
    localparam logic [DVSR_W-1:0] SEC_PER_DAY  = 23'd86400;
    localparam logic [DVSR_W-1:0] SEC_PER_HOUR = 23'd3600;
    localparam logic [DVSR_W-1:0] SEC_PER_MIN  = 23'd60;
    localparam logic [DVSR_W-1:0] FRAC_PER_MS  = 23'd4294967;

    // Step counts for each division
    localparam logic [STEP_W-1:0] STEPS_FULL = 6'd33;
    localparam logic [STEP_W-1:0] STEPS_HOUR = 6'd17;
    localparam logic [STEP_W-1:0] STEPS_MIN  = 6'd12;

    localparam logic [9:0] MS_MAX = 10'd999;

    // Calendar walk: starts at 1968-01-01, which every timestamp follows
    localparam int unsigned YEAR_W    = 12;
    localparam int unsigned DAY_W     = 16;   // days since 1968-01-01
    localparam int unsigned DAY_NUM_W = 17;   // days since 1900-01-01
    localparam logic [YEAR_W-1:0]    BASE_YEAR      = 12'd1968;
    localparam logic [DAY_NUM_W-1:0] BASE_DAYS      = 17'd24836;
    localparam logic [YEAR_W-1:0]    SKIP_LEAP_YEAR = 12'd2100;
    localparam logic [DAY_W-1:0]     DAYS_QUAD      = 16'd1461;
    localparam logic [DAY_W-1:0]     DAYS_COMMON    = 16'd365;
    localparam logic [DAY_W-1:0]     DAYS_LEAP      = 16'd366;

    localparam logic [3:0] MONTH_FEB = 4'd1;
    localparam logic [4:0] FEB_LEAP_DAYS = 5'd29;

    // Payload words
    typedef struct packed {
        logic [31:0] ntp_seconds;
        logic [31:0] ntp_fraction;
    } in_word_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  millisecond;
    } out_word_t;

    // Divider request and result
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DIV_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quotient;
        logic [DVSR_W-1:0] remainder;
    } div_res_t;

    // Calendar status
    typedef struct packed {
        logic        busy;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
    } cal_stat_t;

    // Month length, month index 0 is January
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd0:    len = 5'd31;
            4'd1:    len = 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        if (leap && (m == MONTH_FEB)) begin
            len = FEB_LEAP_DAYS;
        end
        return len;
    endfunction

endpackage

// ===== rtl/ntsu_serdiv.sv =====
// Restoring divider, one quotient bit per cycle.
// The dividend is loaded left aligned; after N steps the low N bits of the
// quotient field hold the quotient.
module ntsu_serdiv (
    input  logic                aclk,
    input  logic                aresetn,
    input  ntsu_pkg::div_req_t  req,
    output ntsu_pkg::div_res_t  res
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [ntsu_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic [ntsu_pkg::DIV_W-1:0]  work_reg, work_next;
    logic [ntsu_pkg::DVSR_W-1:0] rem_reg, rem_next;
    logic [ntsu_pkg::DVSR_W-1:0] dvsr_reg, dvsr_next;

    logic [ntsu_pkg::DVSR_W:0]   trial;
    logic [ntsu_pkg::DVSR_W:0]   diff;
    logic                        fits;

    // One trial subtract per step
    assign trial = {rem_reg, work_reg[ntsu_pkg::DIV_W-1]};
    assign diff  = trial - {1'b0, dvsr_reg};
    assign fits  = (trial >= {1'b0, dvsr_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            work_next = req.dividend;
            rem_next  = '0;
            dvsr_next = req.divisor;
        end else if (busy_reg) begin
            work_next = {work_reg[ntsu_pkg::DIV_W-2:0], fits};
            rem_next  = fits ? diff[ntsu_pkg::DVSR_W-1:0] : trial[ntsu_pkg::DVSR_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == ntsu_pkg::STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign res.done      = done_reg;
    assign res.quotient  = work_reg;
    assign res.remainder = rem_reg;

endmodule

// ===== rtl/ntsu_cal.sv =====
// Day count to calendar date: four-year blocks up to 2100, then single
// years, then months. One step per cycle.
module ntsu_cal (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [ntsu_pkg::DAY_NUM_W-1:0] days,
    output ntsu_pkg::cal_stat_t            stat
);

    typedef enum logic [1:0] {
        CAL_IDLE,
        CAL_YEAR,
        CAL_MONTH
    } cal_state_t;

    cal_state_t                  state_reg, state_next;
    logic [ntsu_pkg::DAY_W-1:0]  days_reg, days_next;
    logic [ntsu_pkg::YEAR_W-1:0] year_reg, year_next;
    logic [3:0]                  month_reg, month_next;
    logic                        leap_reg, leap_next;

    logic                        leap;
    logic                        quad_ok;
    logic [ntsu_pkg::DAY_W-1:0]  ylen;
    logic [ntsu_pkg::DAY_W-1:0]  mlen;
    logic [ntsu_pkg::DAY_NUM_W-1:0] days_rel;

    // Gregorian rule over 1968..2104: only 2100 breaks the four-year pattern
    assign leap    = (year_reg[1:0] == 2'b00) && (year_reg != ntsu_pkg::SKIP_LEAP_YEAR);
    assign quad_ok = (year_reg < ntsu_pkg::SKIP_LEAP_YEAR) && (year_reg[1:0] == 2'b00)
                     && (days_reg >= ntsu_pkg::DAYS_QUAD);
    assign ylen    = leap ? ntsu_pkg::DAYS_LEAP : ntsu_pkg::DAYS_COMMON;
    assign mlen    = {11'd0, ntsu_pkg::month_days(month_reg, leap_reg)};
    assign days_rel = days - ntsu_pkg::BASE_DAYS;

    always_comb begin
        state_next = state_reg;
        days_next  = days_reg;
        year_next  = year_reg;
        month_next = month_reg;
        leap_next  = leap_reg;
        case (state_reg)
            CAL_IDLE: begin
                if (start) begin
                    days_next  = days_rel[ntsu_pkg::DAY_W-1:0];
                    year_next  = ntsu_pkg::BASE_YEAR;
                    state_next = CAL_YEAR;
                end
            end
            CAL_YEAR: begin
                if (quad_ok) begin
                    days_next = days_reg - ntsu_pkg::DAYS_QUAD;
                    year_next = year_reg + ntsu_pkg::YEAR_W'(4);
                end else if (days_reg < ylen) begin
                    leap_next  = leap;
                    month_next = '0;
                    state_next = CAL_MONTH;
                end else begin
                    days_next = days_reg - ylen;
                    year_next = year_reg + 1'b1;
                end
            end
            CAL_MONTH: begin
                if (days_reg < mlen) begin
                    state_next = CAL_IDLE;
                end else begin
                    days_next  = days_reg - mlen;
                    month_next = month_reg + 1'b1;
                end
            end
            default: begin
                state_next = CAL_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CAL_IDLE;
        end else begin
            state_reg <= state_next;
        end
        days_reg  <= days_next;
        year_reg  <= year_next;
        month_reg <= month_next;
        leap_reg  <= leap_next;
    end

    // Date is valid while idle after a walk
    assign stat.busy         = (state_reg != CAL_IDLE);
    assign stat.year         = year_reg;
    assign stat.month        = month_reg + 4'd1;
    assign stat.day_of_month = days_reg[4:0] + 5'd1;

endmodule

// ===== rtl/ntp_timestamp_to_utc_unit.sv =====
// NTP timestamp to UTC date and time.
// Input channel s_valid/s_ready/s_data carries one word: 32-bit NTP seconds
// and 32-bit fraction. Seconds with the top bit clear are taken as era 1.
// Output channel m_valid/m_ready/m_data carries one word per input word:
// year, month, day, hour, minute, second and millisecond.
// A shared bit-serial divider does the day split (the millisecond divide
// runs alongside), then the hour and minute splits, while the calendar walk
// steps four-year blocks, years and months one per cycle; the longer of the
// two paths decides when m_valid rises. One word is worked at a time: no
// new word is accepted until the sequencer is back in idle.
// The result sits in an output register; a new word is accepted while it
// waits. If the receiver stalls, the next result is held inside until the
// output register frees up, and no further word is taken meanwhile.
// Reset (aresetn low, synchronous) empties the output and returns to idle.
module ntp_timestamp_to_utc_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ntsu_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ntsu_pkg::out_word_t m_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DAY,
        ST_HOUR,
        ST_MIN,
        ST_FIN
    } state_t;

    state_t              state_reg, state_next;
    logic [4:0]          hour_reg, hour_next;
    logic [5:0]          min_reg, min_next;
    logic [5:0]          sec_reg, sec_next;
    logic [9:0]          ms_reg, ms_next;
    logic                m_valid_reg, m_valid_next;
    ntsu_pkg::out_word_t m_data_reg, m_data_next;

    ntsu_pkg::div_req_t  req_a, req_b;
    ntsu_pkg::div_res_t  res_a, res_b;
    ntsu_pkg::cal_stat_t cal_stat;
    logic                cal_start;
    logic                out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // Time split divider: day, then hour, then minute
    always_comb begin
        req_a.start    = 1'b0;
        req_a.steps    = ntsu_pkg::STEPS_FULL;
        req_a.dividend = {~s_data.ntp_seconds[31], s_data.ntp_seconds};
        req_a.divisor  = ntsu_pkg::SEC_PER_DAY;
        case (state_reg)
            ST_IDLE: begin
                req_a.start = s_valid;
            end
            ST_DAY: begin
                req_a.start    = res_a.done;
                req_a.steps    = ntsu_pkg::STEPS_HOUR;
                req_a.dividend = {res_a.remainder[16:0], 16'd0};
                req_a.divisor  = ntsu_pkg::SEC_PER_HOUR;
            end
            ST_HOUR: begin
                req_a.start    = res_a.done;
                req_a.steps    = ntsu_pkg::STEPS_MIN;
                req_a.dividend = {res_a.remainder[11:0], 21'd0};
                req_a.divisor  = ntsu_pkg::SEC_PER_MIN;
            end
            default: begin
                req_a.start = 1'b0;
            end
        endcase
    end

    // Millisecond divider runs with the day split
    assign req_b.start    = (state_reg == ST_IDLE) && s_valid;
    assign req_b.steps    = ntsu_pkg::STEPS_FULL;
    assign req_b.dividend = {1'b0, s_data.ntp_fraction};
    assign req_b.divisor  = ntsu_pkg::FRAC_PER_MS;

    assign cal_start = (state_reg == ST_DAY) && res_a.done;

    ntsu_serdiv u_div_time (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req_a),
        .res     (res_a)
    );

    ntsu_serdiv u_div_ms (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req_b),
        .res     (res_b)
    );

    ntsu_cal u_cal (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cal_start),
        .days    (res_a.quotient[ntsu_pkg::DAY_NUM_W-1:0]),
        .stat    (cal_stat)
    );

    // Sequencer and output register
    always_comb begin
        state_next   = state_reg;
        hour_next    = hour_reg;
        min_next     = min_reg;
        sec_next     = sec_reg;
        ms_next      = ms_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DAY;
                end
            end
            ST_DAY: begin
                if (res_a.done) begin
                    ms_next = (res_b.quotient > {23'd0, ntsu_pkg::MS_MAX}) ?
                              ntsu_pkg::MS_MAX : res_b.quotient[9:0];
                    state_next = ST_HOUR;
                end
            end
            ST_HOUR: begin
                if (res_a.done) begin
                    hour_next  = res_a.quotient[4:0];
                    state_next = ST_MIN;
                end
            end
            ST_MIN: begin
                if (res_a.done) begin
                    min_next   = res_a.quotient[5:0];
                    sec_next   = res_a.remainder[5:0];
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!cal_stat.busy && out_free) begin
                    m_data_next.year         = cal_stat.year;
                    m_data_next.month        = cal_stat.month;
                    m_data_next.day_of_month = cal_stat.day_of_month;
                    m_data_next.hour         = hour_reg;
                    m_data_next.minute       = min_reg;
                    m_data_next.second       = sec_reg;
                    m_data_next.millisecond  = ms_reg;
                    m_valid_next             = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        hour_reg   <= hour_next;
        min_reg    <= min_next;
        sec_reg    <= sec_next;
        ms_reg     <= ms_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
